### sv/ppag_pkg.sv
// Shared types and constants for the plane pack address generator.
`default_nettype none
package ppag_pkg;

  localparam int PLANES_DEF  = 4;
  localparam int ADDR_W      = 30;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_COUNT    = 3'd0,
    CFG_ELEMENT_BYTES  = 3'd1,
    CFG_PLANE_MAP      = 3'd2,
    CFG_PLANE_OFFSETS  = 3'd3,
    CFG_PLANAR_STRIDES = 3'd4,
    CFG_PACKED_STRIDES = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  plane_count;
    logic [3:0]  element_bytes;
    logic [7:0]  plane_map;
    logic [15:0] plane_offsets;
    logic [63:0] planar_strides;
    logic [63:0] packed_strides;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  packed_plane;
    logic [3:0]  offset;
    logic [3:0]  element_bytes;
    logic [6:0]  pixel_bytes;
    logic [15:0] packed_stride;
    logic [15:0] planar_stride;
    logic [11:0] row;
    logic [11:0] column;
    logic [63:0] data;
  } dec_t;

  typedef struct packed {
    logic [1:0]  packed_plane;
    logic [7:0]  off_term;
    logic [27:0] pk_row_term;
    logic [18:0] pk_col_term;
    logic [27:0] pl_row_term;
    logic [15:0] pl_col_term;
    logic [63:0] data;
  } prod_t;

endpackage
`default_nettype wire

### sv/plane_pack_address_generator.sv
// Top level of the planar/packed interleave address generator.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | start / busy       | in_source_plane, in_row, in_column,
//            |                    | in_element_data
//   result   | out_valid (strobe) | out_packed_plane, out_packed_address,
//            |                    | out_planar_address, out_element_out
//   config   | cfg_we             | cfg_index, cfg_data
//
// One item per cycle.
// Three register stages: decode, multiply, sum; the sum stage is the output.
// busy is always low; the pipeline never holds since results are not stalled.
// Synchronous active-low reset clears valid bits and restores register defaults.
`default_nettype none
module plane_pack_address_generator #(
  parameter int PLANES = ppag_pkg::PLANES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_source_plane,
  input  wire logic [11:0]                      in_row,
  input  wire logic [11:0]                      in_column,
  input  wire logic [63:0]                      in_element_data,
  output logic                                  out_valid,
  output logic [1:0]                            out_packed_plane,
  output logic [ppag_pkg::ADDR_W-1:0]           out_packed_address,
  output logic [ppag_pkg::ADDR_W-1:0]           out_planar_address,
  output logic [63:0]                           out_element_out,
  input  wire logic                             cfg_we,
  input  wire logic [ppag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ppag_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ppag_pkg::cfg_t  cfg;
  logic            dec_valid;
  ppag_pkg::dec_t  dec;
  logic            prod_valid;
  ppag_pkg::prod_t prod;
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ppag_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppag_decode #(
    .PLANES (PLANES)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (accept),
    .source_plane (in_source_plane),
    .row          (in_row),
    .column       (in_column),
    .element_data (in_element_data),
    .dec_valid    (dec_valid),
    .dec          (dec)
  );

  ppag_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec_valid  (dec_valid),
    .dec        (dec),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  ppag_sum u_sum (
    .clk                (clk),
    .rst_n              (rst_n),
    .prod_valid         (prod_valid),
    .prod               (prod),
    .out_valid          (out_valid),
    .out_packed_plane   (out_packed_plane),
    .out_packed_address (out_packed_address),
    .out_planar_address (out_planar_address),
    .out_element_out    (out_element_out)
  );

endmodule
`default_nettype wire

### sv/ppag_cfg_regs.sv
// Configuration register file.
`default_nettype none
module ppag_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [ppag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ppag_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ppag_pkg::cfg_t                          cfg
);

  ppag_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (ppag_pkg::cfg_idx_t'(cfg_index))
        ppag_pkg::CFG_PLANE_COUNT:    cfg_nxt.plane_count    = cfg_data[2:0];
        ppag_pkg::CFG_ELEMENT_BYTES:  cfg_nxt.element_bytes  = cfg_data[3:0];
        ppag_pkg::CFG_PLANE_MAP:      cfg_nxt.plane_map      = cfg_data[7:0];
        ppag_pkg::CFG_PLANE_OFFSETS:  cfg_nxt.plane_offsets  = cfg_data[15:0];
        ppag_pkg::CFG_PLANAR_STRIDES: cfg_nxt.planar_strides = cfg_data[63:0];
        ppag_pkg::CFG_PACKED_STRIDES: cfg_nxt.packed_strides = cfg_data[63:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane_count    <= 3'd1;
      cfg_r.element_bytes  <= 4'd1;
      cfg_r.plane_map      <= '0;
      cfg_r.plane_offsets  <= '0;
      cfg_r.planar_strides <= '0;
      cfg_r.packed_strides <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/ppag_decode.sv
// Stage 1: plane lookup, sharing count and pixel size.
`default_nettype none
module ppag_decode #(
  parameter int PLANES = ppag_pkg::PLANES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ppag_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  input  wire logic [1:0]      source_plane,
  input  wire logic [11:0]     row,
  input  wire logic [11:0]     column,
  input  wire logic [63:0]     element_data,
  output logic                 dec_valid,
  output ppag_pkg::dec_t       dec
);

  logic           valid_r, valid_nxt;
  ppag_pkg::dec_t dec_r, dec_nxt;
  logic [2:0]     active;
  logic [1:0]     m;
  logic [2:0]     sharing;

  always_comb begin
    active = (cfg.plane_count > 3'(PLANES)) ? 3'(PLANES) : cfg.plane_count;
    m = cfg.plane_map[2*source_plane +: 2];
    sharing = '0;
    for (int q = 0; q < PLANES; q++) begin
      if ((3'(q) < active) && (cfg.plane_map[2*q +: 2] == m))
        sharing = sharing + 3'd1;
    end
  end

  always_comb begin
    valid_nxt             = in_valid;
    dec_nxt.packed_plane  = m;
    dec_nxt.offset        = cfg.plane_offsets[4*source_plane +: 4];
    dec_nxt.element_bytes = cfg.element_bytes;
    dec_nxt.pixel_bytes   = 7'(sharing) * 7'(cfg.element_bytes);
    dec_nxt.packed_stride = cfg.packed_strides[16*m +: 16];
    dec_nxt.planar_stride = cfg.planar_strides[16*source_plane +: 16];
    dec_nxt.row           = row;
    dec_nxt.column        = column;
    dec_nxt.data          = element_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
  end

  assign dec_valid = valid_r;
  assign dec       = dec_r;

endmodule
`default_nettype wire

### sv/ppag_mul.sv
// Stage 2: independent address term products.
`default_nettype none
module ppag_mul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            dec_valid,
  input  wire ppag_pkg::dec_t  dec,
  output logic                 prod_valid,
  output ppag_pkg::prod_t      prod
);

  logic            valid_r, valid_nxt;
  ppag_pkg::prod_t prod_r, prod_nxt;

  always_comb begin
    valid_nxt             = dec_valid;
    prod_nxt.packed_plane = dec.packed_plane;
    prod_nxt.off_term     = 8'(dec.offset) * 8'(dec.element_bytes);
    prod_nxt.pk_row_term  = 28'(dec.row) * 28'(dec.packed_stride);
    prod_nxt.pk_col_term  = 19'(dec.column) * 19'(dec.pixel_bytes);
    prod_nxt.pl_row_term  = 28'(dec.row) * 28'(dec.planar_stride);
    prod_nxt.pl_col_term  = 16'(dec.column) * 16'(dec.element_bytes);
    prod_nxt.data         = dec.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod_valid = valid_r;
  assign prod       = prod_r;

endmodule
`default_nettype wire

### sv/ppag_sum.sv
// Stage 3: address sums and result register.
`default_nettype none
module ppag_sum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        prod_valid,
  input  wire ppag_pkg::prod_t             prod,
  output logic                             out_valid,
  output logic [1:0]                       out_packed_plane,
  output logic [ppag_pkg::ADDR_W-1:0]      out_packed_address,
  output logic [ppag_pkg::ADDR_W-1:0]      out_planar_address,
  output logic [63:0]                      out_element_out
);

  localparam int AW = ppag_pkg::ADDR_W;

  logic          valid_r, valid_nxt;
  logic [1:0]    plane_r, plane_nxt;
  logic [AW-1:0] pk_addr_r, pk_addr_nxt;
  logic [AW-1:0] pl_addr_r, pl_addr_nxt;
  logic [63:0]   data_r, data_nxt;

  always_comb begin
    valid_nxt   = prod_valid;
    plane_nxt   = prod.packed_plane;
    pk_addr_nxt = AW'(prod.off_term) + AW'(prod.pk_row_term) + AW'(prod.pk_col_term);
    pl_addr_nxt = AW'(prod.pl_row_term) + AW'(prod.pl_col_term);
    data_nxt    = prod.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plane_r   <= plane_nxt;
    pk_addr_r <= pk_addr_nxt;
    pl_addr_r <= pl_addr_nxt;
    data_r    <= data_nxt;
  end

  assign out_valid          = valid_r;
  assign out_packed_plane   = plane_r;
  assign out_packed_address = pk_addr_r;
  assign out_planar_address = pl_addr_r;
  assign out_element_out    = data_r;

endmodule
`default_nettype wire

### bench/plane_pack_address_generator_test.sv
// Self-checking testbench for the planar/packed interleave address generator.
module plane_pack_address_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppag_pkg::*;

  localparam int PIPE_DEPTH  = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    logic [1:0]        plane;
    logic [ADDR_W-1:0] packed_addr;
    logic [ADDR_W-1:0] planar_addr;
    logic [63:0]       data;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_source_plane = '0;
  logic [11:0]           in_row = '0;
  logic [11:0]           in_column = '0;
  logic [63:0]           in_element_data = '0;
  logic                  out_valid;
  logic [1:0]            out_packed_plane;
  logic [ADDR_W-1:0]     out_packed_address;
  logic [ADDR_W-1:0]     out_planar_address;
  logic [63:0]           out_element_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t       regs;
  placement_t pending_placements[$];
  int         errors = 0;
  int         cycles = 0;

  plane_pack_address_generator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_source_plane(in_source_plane), .in_row(in_row), .in_column(in_column),
    .in_element_data(in_element_data),
    .out_valid(out_valid), .out_packed_plane(out_packed_plane),
    .out_packed_address(out_packed_address), .out_planar_address(out_planar_address),
    .out_element_out(out_element_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycles,
               pending_placements.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Expected placement of one element under the current register settings.
  function automatic placement_t place_element(logic [1:0] plane, logic [11:0] row,
                                               logic [11:0] col, logic [63:0] data);
    placement_t  r;
    int unsigned active, sharing, offset, eb, r32, c32, pk_sum, pl_sum;
    logic [1:0]  target;
    active  = (regs.plane_count > 3'd4) ? 4 : 32'(regs.plane_count);
    target  = regs.plane_map[plane*2 +: 2];
    sharing = 0;
    for (int q = 0; q < 4; q++) begin
      if (q < active && regs.plane_map[q*2 +: 2] == target) sharing++;
    end
    offset = 32'(regs.plane_offsets[plane*4 +: 4]);
    eb     = 32'(regs.element_bytes);
    r32    = 32'(row);
    c32    = 32'(col);
    pk_sum = offset * eb + r32 * 32'(regs.packed_strides[target*16 +: 16])
           + c32 * sharing * eb;
    pl_sum = r32 * 32'(regs.planar_strides[plane*16 +: 16]) + c32 * eb;
    r.plane       = target;
    r.packed_addr = pk_sum[ADDR_W-1:0];
    r.planar_addr = pl_sum[ADDR_W-1:0];
    r.data        = data;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk) begin : check_results
    placement_t want;
    if (rst_n && out_valid) begin
      if (pending_placements.size() == 0) begin
        report_mismatch("result with no item pending", 64'(out_packed_address), 64'd0);
      end else begin
        want = pending_placements.pop_front();
        if (out_packed_plane !== want.plane)
          report_mismatch("packed_plane", 64'(out_packed_plane), 64'(want.plane));
        if (out_packed_address !== want.packed_addr)
          report_mismatch("packed_address", 64'(out_packed_address),
                          64'(want.packed_addr));
        if (out_planar_address !== want.planar_addr)
          report_mismatch("planar_address", 64'(out_planar_address),
                          64'(want.planar_addr));
        if (out_element_out !== want.data)
          report_mismatch("element_out", out_element_out, want.data);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(logic [1:0] plane, logic [11:0] row, logic [11:0] col,
                           logic [63:0] data, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start           = 1'b1;
    in_source_plane = plane;
    in_row          = row;
    in_column       = col;
    in_element_data = data;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_placements.push_back(place_element(plane, row, col, data));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    case (idx)
      CFG_PLANE_COUNT:    regs.plane_count    = value[2:0];
      CFG_ELEMENT_BYTES:  regs.element_bytes  = value[3:0];
      CFG_PLANE_MAP:      regs.plane_map      = value[7:0];
      CFG_PLANE_OFFSETS:  regs.plane_offsets  = value[15:0];
      CFG_PLANAR_STRIDES: regs.planar_strides = value;
      CFG_PACKED_STRIDES: regs.packed_strides = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_config(logic [2:0] count, logic [3:0] eb, logic [7:0] map,
                             logic [15:0] offsets, logic [63:0] pl_str, logic [63:0] pk_str);
    wait_for_results();
    write_reg(CFG_PLANE_COUNT, 64'(count));
    write_reg(CFG_ELEMENT_BYTES, 64'(eb));
    write_reg(CFG_PLANE_MAP, 64'(map));
    write_reg(CFG_PLANE_OFFSETS, 64'(offsets));
    write_reg(CFG_PLANAR_STRIDES, pl_str);
    write_reg(CFG_PACKED_STRIDES, pk_str);
  endtask

  task automatic test_reset_defaults();
    send_item(2'd0, 12'd0, 12'd0, 64'd0, 0);
    send_item(2'd3, 12'd4095, 12'd4095, '1, 0);
    send_item(2'd1, 12'd17, 12'd300, 64'h0123_4567_89ab_cdef, 1);
  endtask

  task automatic test_directed_corners();
    // identity map, offsets, strides and coordinates at maximum
    load_config(3'd4, 4'd8, 8'hE4, 16'hFFFF, '1, '1);
    for (int p = 0; p < 4; p++)
      send_item(2'(p), 12'd4095, 12'd4095, (p % 2) ? '1 : 64'h8000_0000_0000_0001, 0);
    // count above plane limit saturates, everything shares packed plane 0, oversize element
    load_config(3'd7, 4'd15, 8'h00, 16'hFFFF, '1, '1);
    send_item(2'd0, 12'd4095, 12'd4095, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    send_item(2'd3, 12'd0, 12'd4095, 64'h5555_5555_5555_5555, 0);
    send_item(2'd2, 12'd4095, 12'd0, 64'd0, 2);
    // zero planes active, zero element size
    load_config(3'd0, 4'd0, 8'hFF, 16'h1234, 64'h0001_0002_0003_0004,
                64'hFFFF_0000_FFFF_0000);
    send_item(2'd0, 12'd4095, 12'd4095, 64'd1, 0);
    send_item(2'd3, 12'd100, 12'd200, 64'hFFFF_FFFF_0000_0000, 0);
    send_item(2'd1, 12'd1, 12'd1, 64'h0000_0000_FFFF_FFFF, 0);
    // two packed planes, planes 2 and 3 inactive
    load_config(3'd2, 4'd3, 8'h50, 16'h3210, 64'h0100_0200_0300_0400,
                64'h1000_2000_3000_4000);
    for (int p = 0; p < 4; p++)
      send_item(2'(p), 12'(p * 1000 + 5), 12'(4095 - p), {$urandom, $urandom}, 0);
  endtask

  task automatic random_config();
    logic [2:0]  count;
    logic [3:0]  eb;
    logic [63:0] pl_str, pk_str;
    count  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(1, 4));
    eb     = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 8));
    pl_str = {$urandom, $urandom};
    pk_str = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) pl_str = '1;
    if ($urandom_range(0, 5) == 0) pk_str = '0;
    load_config(count, eb, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                pl_str, pk_str);
  endtask

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_random_settings();
    int count;
    for (int phase = 0; phase < 24; phase++) begin
      random_config();
      count = $urandom_range(45, 80);
      for (int n = 0; n < count; n++) begin
        if (n == count / 2 && phase % 4 == 0) wait_for_results();
        send_item(2'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                  {$urandom, $urandom}, pick_gap());
      end
    end
  endtask

  task automatic test_back_to_back();
    random_config();
    for (int n = 0; n < 80; n++)
      send_item(2'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                {$urandom, $urandom}, 0);
  endtask

  initial begin
    regs.plane_count    = 3'd1;
    regs.element_bytes  = 4'd1;
    regs.plane_map      = '0;
    regs.plane_offsets  = '0;
    regs.planar_strides = '0;
    regs.packed_strides = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_directed_corners();
    test_random_settings();
    test_back_to_back();
    wait_for_results();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/ppag_pkg.sv
sv/ppag_cfg_regs.sv
sv/ppag_decode.sv
sv/ppag_mul.sv
sv/ppag_sum.sv
sv/plane_pack_address_generator.sv
bench/plane_pack_address_generator_test.sv
